[rtl/rna_pkg.sv]
package rna_pkg;

  // Word width of the fraction fields.
  localparam int WORD_BITS = 32;

  // Operand width of the shared multiplier (one sign bit of headroom).
  localparam int MUL_BITS = WORD_BITS + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;
  // Width of the magnitudes handled by the gcd and divide steps.
  localparam int MAG_BITS = 2 * WORD_BITS;
  localparam int SHIFT_BITS = $clog2(MAG_BITS);

  // Largest magnitude that fits a result field.
  localparam logic [MAG_BITS-1:0] LIMIT = (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1);

  // Operation codes.
  localparam logic [2:0] KIND_MAKE = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_SUB  = 3'd2;
  localparam logic [2:0] KIND_MUL  = 3'd3;
  localparam logic [2:0] KIND_DIV  = 3'd4;
  localparam logic [2:0] KIND_CMP  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_PREP,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_CHK,
    S_FIN
  } state_t;

endpackage

[rtl/rna_if.sv]
interface rna_in_if;
  import rna_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  kind;
  logic signed [WORD_BITS-1:0] a_num;
  logic signed [WORD_BITS-1:0] a_den;
  logic signed [WORD_BITS-1:0] b_num;
  logic [WORD_BITS-2:0]        b_den;

  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rna_out_if;
  import rna_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_num;
  logic [WORD_BITS-2:0]        res_den;
  logic                        is_less;
  logic                        is_equal;
  logic [1:0]                  status;

  modport source (output valid, res_num, res_den, is_less, is_equal, status, input ready);
  modport sink (input valid, res_num, res_den, is_less, is_equal, status, output ready);
endinterface

[rtl/rational_number_alu.sv]
// Channel  Direction  Contents
// req      in         kind, a_num, a_den, b_num, b_den
// rsp      out        res_num, res_den, is_less, is_equal, status
//
// One word is worked at a time: three products on the shared multiplier
// (skipped for make), a setup state, the binary gcd, then the restoring
// divider on the numerator and then the denominator. Errors go straight to
// the result; compares and zero numerators skip the gcd and divide. Reset
// (rst, synchronous) empties the block. A result waits in the output register
// while the next word is taken.
module rational_number_alu (
  input logic clk,
  input logic rst,
  rna_in_if.sink   req,
  rna_out_if.source rsp
);
  import rna_pkg::*;

  state_t state, state_next;

  // Captured operands.
  logic [2:0]                  kind;
  logic signed [WORD_BITS-1:0] an, ad, bn;
  logic [WORD_BITS-2:0]        bd;

  // Products and the reduction datapath.
  logic signed [PROD_BITS-1:0] p1, p2, p3;
  logic [MAG_BITS-1:0]         mn, md, x, y, g, rem, dq, qn;
  logic [SHIFT_BITS-1:0]       k, cnt;
  logic                        neg;

  // Pending result.
  logic signed [WORD_BITS-1:0] r_num;
  logic [WORD_BITS-2:0]        r_den;
  logic                        r_less, r_eq;
  logic [1:0]                  r_st;

  logic out_valid;

  // Shared multiplier.
  logic signed [MUL_BITS-1:0]  ma, mb, an_s, ad_m, an_x, ad_x, bn_x, bd_x;
  logic signed [PROD_BITS-1:0] prod;

  // Numerator and denominator ahead of reduction.
  logic signed [PROD_BITS-1:0] num, den;
  logic [PROD_BITS-1:0]        num_mag, den_mag;

  // Divider step.
  logic [MAG_BITS:0] rem_sh, trial;

  logic accept, fin_take, err_zd, err_dz;

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign fin_take = !out_valid || rsp.ready;

  assign rsp.valid = out_valid;

  // Operand extension and selection for the multiplier.
  always_comb begin
    an_x = {an[WORD_BITS-1], an};
    ad_x = {ad[WORD_BITS-1], ad};
    bn_x = {bn[WORD_BITS-1], bn};
    bd_x = {2'b00, bd};
    an_s = ad[WORD_BITS-1] ? -an_x : an_x;
    ad_m = ad[WORD_BITS-1] ? -ad_x : ad_x;
    unique case (state)
      S_MUL1: begin
        ma = (kind == KIND_CMP) ? an_s : an_x;
        mb = (kind == KIND_MUL) ? bn_x : bd_x;
      end
      S_MUL2: begin
        ma = bn_x;
        mb = (kind == KIND_CMP) ? ad_m : ad_x;
      end
      default: begin
        ma = ad_x;
        mb = (kind == KIND_DIV) ? bn_x : bd_x;
      end
    endcase
    prod = ma * mb;
  end

  // Combine products into one fraction and take magnitudes.
  always_comb begin
    if (kind == KIND_ADD) begin
      num = p1 + p2;
    end else if (kind == KIND_SUB) begin
      num = p1 - p2;
    end else begin
      num = p1;
    end
    den = p3;
    num_mag = num[PROD_BITS-1] ? PROD_BITS'(-num) : PROD_BITS'(num);
    den_mag = den[PROD_BITS-1] ? PROD_BITS'(-den) : PROD_BITS'(den);
  end

  // One restoring-division step.
  always_comb begin
    rem_sh = {rem, dq[MAG_BITS-1]};
    trial = rem_sh - {1'b0, g};
  end

  // Input checks at acceptance.
  always_comb begin
    err_zd = 1'b0;
    err_dz = 1'b0;
    if (req.kind == KIND_MAKE) begin
      err_zd = (req.a_den == '0);
    end else if (req.kind <= KIND_CMP) begin
      err_zd = (req.a_den == '0) || (req.b_den == '0);
      err_dz = (req.kind == KIND_DIV) && (req.b_num == '0);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (err_zd || err_dz || req.kind > KIND_CMP) begin
            state_next = S_FIN;
          end else if (req.kind == KIND_MAKE) begin
            state_next = S_PREP;
          end else begin
            state_next = S_MUL1;
          end
        end
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_PREP;
      S_PREP: begin
        if (kind == KIND_CMP || num == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: if (x == y) state_next = S_DIVN;
      S_DIVN: if (cnt == '1) state_next = S_DIVD;
      S_DIVD: if (cnt == '1) state_next = S_CHK;
      S_CHK: state_next = S_FIN;
      S_FIN: if (fin_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        kind <= req.kind;
        an <= req.a_num;
        ad <= req.a_den;
        bn <= req.b_num;
        bd <= req.b_den;
        p1 <= PROD_BITS'(req.a_num);
        p2 <= '0;
        p3 <= PROD_BITS'(req.a_den);
        r_num <= '0;
        r_den <= (WORD_BITS-1)'(1);
        r_less <= 1'b0;
        r_eq <= !(err_zd || err_dz) && (req.kind == KIND_CMP)
                && (req.a_num == req.b_num)
                && (req.a_den == $signed({1'b0, req.b_den}));
        r_st <= err_zd ? ST_ZERO_DEN : (err_dz ? ST_DIV_ZERO : ST_OK);
      end
      S_MUL1: p1 <= prod;
      S_MUL2: p2 <= prod;
      S_MUL3: p3 <= prod;
      S_PREP: begin
        if (kind == KIND_CMP) begin
          r_less <= (p1 < p2);
        end
        neg <= num[PROD_BITS-1] ^ den[PROD_BITS-1];
        mn <= num_mag[MAG_BITS-1:0];
        md <= den_mag[MAG_BITS-1:0];
        x <= num_mag[MAG_BITS-1:0];
        y <= den_mag[MAG_BITS-1:0];
        k <= '0;
      end
      S_GCD: begin
        // Binary gcd: strip common twos, then halve and subtract.
        if (x == y) begin
          g <= x << k;
          rem <= '0;
          dq <= mn;
          cnt <= '0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + SHIFT_BITS'(1);
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        cnt <= cnt + SHIFT_BITS'(1);
        // The last numerator step keeps the quotient and loads the denominator.
        if (state == S_DIVN && cnt == '1) begin
          qn <= trial[MAG_BITS] ? {dq[MAG_BITS-2:0], 1'b0} : {dq[MAG_BITS-2:0], 1'b1};
          rem <= '0;
          dq <= md;
        end else if (!trial[MAG_BITS]) begin
          rem <= trial[MAG_BITS-1:0];
          dq <= {dq[MAG_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_sh[MAG_BITS-1:0];
          dq <= {dq[MAG_BITS-2:0], 1'b0};
        end
      end
      S_CHK: begin
        if (qn > LIMIT || dq > LIMIT) begin
          r_st <= ST_OVERFLOW;
        end else begin
          r_num <= neg ? -$signed(qn[WORD_BITS-1:0]) : $signed(qn[WORD_BITS-1:0]);
          r_den <= dq[WORD_BITS-2:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && fin_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && fin_take) begin
      rsp.res_num <= r_num;
      rsp.res_den <= r_den;
      rsp.is_less <= r_less;
      rsp.is_equal <= r_eq;
      rsp.status <= r_st;
    end
  end

endmodule

[bench/rational_number_alu_tb.sv]
`timescale 1ns / 1ps

module rational_number_alu_tb;
  import rna_pkg::*;

  logic clk;
  logic rst;

  rna_in_if  req ();
  rna_out_if rsp ();

  rational_number_alu DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  typedef struct {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
    logic               is_equal;
    logic [1:0]         status;
  } fraction_result_t;

  // Keeps the expected results of accepted words in order and checks each
  // returned word against the oldest one.
  class fraction_scoreboard;
    fraction_result_t pending[$];
    int errors;

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Reduce num/den by the gcd; den is nonzero.
    function logic [1:0] reduce_fraction(longint num, longint den,
                                         ref fraction_result_t r);
      longint unsigned mn, md, x, y, t;
      bit neg;
      if (num == 0) return ST_OK;
      neg = (num < 0) != (den < 0);
      mn = num < 0 ? -num : num;
      md = den < 0 ? -den : den;
      x = mn;
      y = md;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      mn = mn / x;
      md = md / x;
      if (mn > 64'h7FFF_FFFF || md > 64'h7FFF_FFFF) return ST_OVERFLOW;
      r.res_num = neg ? -mn[31:0] : mn[31:0];
      r.res_den = md[30:0];
      return ST_OK;
    endfunction

    function void note_word(logic [2:0] kind, logic signed [31:0] a_num,
                            logic signed [31:0] a_den, logic signed [31:0] b_num,
                            logic [30:0] b_den);
      fraction_result_t r;
      longint an, ad, bn, bd, an_s, ad_m;
      logic [1:0] st;
      an = a_num;
      ad = a_den;
      bn = b_num;
      bd = {33'd0, b_den};
      r.res_num = 0;
      r.res_den = 1;
      r.is_less = 0;
      r.is_equal = 0;
      st = ST_OK;
      if (kind == KIND_MAKE) begin
        if (ad == 0) st = ST_ZERO_DEN;
        else st = reduce_fraction(an, ad, r);
      end else if (kind <= KIND_CMP) begin
        if (ad == 0 || bd == 0) st = ST_ZERO_DEN;
        else begin
          case (kind)
            KIND_ADD: st = reduce_fraction(an * bd + bn * ad, ad * bd, r);
            KIND_SUB: st = reduce_fraction(an * bd - bn * ad, ad * bd, r);
            KIND_MUL: st = reduce_fraction(an * bn, ad * bd, r);
            KIND_DIV: begin
              if (bn == 0) st = ST_DIV_ZERO;
              else st = reduce_fraction(an * bd, ad * bn, r);
            end
            default: begin
              // Cross-multiplied test with the sign of a_den moved up.
              an_s = ad < 0 ? -an : an;
              ad_m = ad < 0 ? -ad : ad;
              r.is_less = (an_s * bd < bn * ad_m);
              r.is_equal = (an == bn && ad == bd);
            end
          endcase
        end
      end
      if (st != ST_OK) begin
        r.res_num = 0;
        r.res_den = 1;
        r.is_less = 0;
        r.is_equal = 0;
      end
      r.status = st;
      pending.push_back(r);
    endfunction

    task check_word(fraction_result_t got);
      fraction_result_t exp_r;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp_r = pending.pop_front();
      if (got.res_num !== exp_r.res_num)
        report($sformatf("res_num %0d, wanted %0d", got.res_num, exp_r.res_num));
      if (got.res_den !== exp_r.res_den)
        report($sformatf("res_den %0d, wanted %0d", got.res_den, exp_r.res_den));
      if (got.is_less !== exp_r.is_less)
        report($sformatf("is_less %b, wanted %b", got.is_less, exp_r.is_less));
      if (got.is_equal !== exp_r.is_equal)
        report($sformatf("is_equal %b, wanted %b", got.is_equal, exp_r.is_equal));
      if (got.status !== exp_r.status)
        report($sformatf("status %0d, wanted %0d", got.status, exp_r.status));
    endtask
  endclass

  fraction_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  // Monitor both channels at the rising edge.
  always @(posedge clk) begin
    fraction_result_t got;
    if (!rst && req.valid && req.ready)
      sb.note_word(req.kind, req.a_num, req.a_den, req.b_num, req.b_den);
    if (!rst && rsp.valid && rsp.ready) begin
      got.res_num = rsp.res_num;
      got.res_den = rsp.res_den;
      got.is_less = rsp.is_less;
      got.is_equal = rsp.is_equal;
      got.status = rsp.status;
      sb.check_word(got);
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready = 0;
      end else begin
        rsp.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one word and wait until it is taken, then maybe leave a gap.
  task send_word(logic [2:0] kind, logic signed [31:0] a_num, logic signed [31:0] a_den,
                 logic signed [31:0] b_num, logic [30:0] b_den);
    req.kind = kind;
    req.a_num = a_num;
    req.a_den = a_den;
    req.b_num = b_num;
    req.b_den = b_den;
    req.valid = 1;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Mix of small, medium, full-width, extreme and power-of-two values.
  function logic signed [31:0] pick_value(bit nonzero);
    logic signed [31:0] v;
    case ($urandom_range(5))
      0, 1: v = int'($urandom_range(40)) - 20;
      2: v = int'($urandom_range(2000)) - 1000;
      3: begin
        v = $urandom;
        if (v == 32'sh8000_0000) v = 32'sh8000_0001;
      end
      4: v = $urandom_range(1) ? 32'sh7FFF_FFFF : -32'sh7FFF_FFFF;
      default: v = (32'sd1 << $urandom_range(30)) * ($urandom_range(1) ? 1 : -1);
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  function logic [30:0] pick_positive();
    logic signed [31:0] v;
    v = pick_value(1);
    if (v < 0) v = -v;
    return v[30:0];
  endfunction

  // Stimulus.
  initial begin
    logic [2:0] k;
    logic signed [31:0] an, ad, bn;
    logic [30:0] bd;
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    req.valid = 0;
    req.kind = KIND_MAKE;
    req.a_num = 0;
    req.a_den = 1;
    req.b_num = 0;
    req.b_den = 1;
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed words: extremes, every operation, and the special cases.
    send_word(KIND_MAKE, 6, -4, 0, 0);
    send_word(KIND_MAKE, 0, -7, 0, 1);
    send_word(KIND_MAKE, 5, 0, 0, 1);
    send_word(KIND_MAKE, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 0, 1);
    send_word(KIND_ADD, 1, 2, 1, 3);
    send_word(KIND_ADD, 3, 0, 1, 3);
    send_word(KIND_ADD, 1, 2, 1, 0);
    send_word(KIND_ADD, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
    send_word(KIND_SUB, 1, 2, 1, 2);
    send_word(KIND_SUB, -32'sh7FFF_FFFF, 2, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(KIND_MUL, 2, 3, -3, 4);
    send_word(KIND_MUL, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
    send_word(KIND_DIV, 1, 2, 0, 5);
    send_word(KIND_DIV, 1, 0, 0, 5);
    send_word(KIND_DIV, 4, -6, -2, 3);
    send_word(KIND_DIV, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    send_word(KIND_CMP, 1, 2, 1, 2);
    send_word(KIND_CMP, 2, 4, 1, 2);
    send_word(KIND_CMP, 1, -2, 0, 1);
    send_word(KIND_CMP, -32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(KIND_CMP, 1, 2, 1, 0);
    send_word(3'd6, 9, 3, 4, 2);
    send_word(3'd7, -1, 0, -1, 0);

    // Random words in phases of idling and stalling.
    for (int i = 0; i < 1100; i++) begin
      case ((i / 100) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      // Long receiver hold-off so the block backs up into its input.
      if (i == 450) hold_request = 3000;
      k = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      an = pick_value(0);
      ad = ($urandom_range(99) < 3) ? 32'sd0 : pick_value(1);
      bn = pick_value(0);
      bd = ($urandom_range(99) < 2) ? 31'd0 : pick_positive();
      send_word(k, an, ad, bn, bd);
    end
    req.valid = 0;

    // Wait for every expected word to come back.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[rational_number_alu.f]
rtl/rna_pkg.sv
rtl/rna_if.sv
rtl/rational_number_alu.sv
bench/rational_number_alu_tb.sv
